FILE: design/bump_index_and_envmap_shade_macros.svh
// Assertion macros shared by the bump index and environment map shader.
// Needs clk and rst in scope at the point of use.
`ifndef BUMP_INDEX_AND_ENVMAP_SHADE_MACROS_SVH
`define BUMP_INDEX_AND_ENVMAP_SHADE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BIE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define BIE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bie_pkg.sv
// Shared types, codes and constants of the bump index / environment map shader.
// No dependencies.
package bie_pkg;

  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 8;

  // Item opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_LIGHT = 2'd2;
  localparam logic [1:0] OP_SHADE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUMP_PRESENT = 8'd1;

  // Result kinds
  localparam logic KIND_BUMP  = 1'b0;
  localparam logic KIND_SHADE = 1'b1;

  // Shared unit operations
  localparam logic [2:0] ALU_NOP  = 3'd0;
  localparam logic [2:0] ALU_LOAD = 3'd1;
  localparam logic [2:0] ALU_ADD  = 3'd2;
  localparam logic [2:0] ALU_SUB  = 3'd3;
  localparam logic [2:0] ALU_BIAS = 3'd4;
  localparam logic [2:0] ALU_DIV3 = 3'd5;

  // Operand selects
  localparam logic [2:0] OPN_RED    = 3'd0;
  localparam logic [2:0] OPN_GREEN  = 3'd1;
  localparam logic [2:0] OPN_BLUE   = 3'd2;
  localparam logic [2:0] OPN_X      = 3'd3;
  localparam logic [2:0] OPN_Y      = 3'd4;
  localparam logic [2:0] OPN_HDATA  = 3'd5;
  localparam logic [2:0] OPN_BDATA  = 3'd6;
  localparam logic [2:0] OPN_OFFSET = 3'd7;

  // Height neighbour selects
  localparam logic [2:0] NB_SELF  = 3'd0;
  localparam logic [2:0] NB_RIGHT = 3'd1;
  localparam logic [2:0] NB_LEFT  = 3'd2;
  localparam logic [2:0] NB_DOWN  = 3'd3;
  localparam logic [2:0] NB_UP    = 3'd4;

  // Slope bias and divide-by-three reciprocal (exact for sums up to 765)
  localparam logic [ADDR_W-1:0] BIAS_C = 16'd128;
  localparam int SUM_W = 10;
  localparam logic [SUM_W-1:0] DIV3_MUL = 10'd683;
  localparam int DIV3_SHIFT = 11;

  typedef struct packed {
    logic [2:0] alu_op;
    logic [2:0] opnd;
    logic       h_rd;
    logic       h_wr;
    logic [2:0] h_nb;
    logic       b_rd;
    logic       b_wr;
    logic       l_rd;
    logic       l_wr;
    logic       l_acc;
    logic       save_bx;
    logic       emit;
    logic       kind;
    logic       zero;
  } bie_ctrl_t;

  // Address offset of a height neighbour; addresses wrap over the whole store
  function automatic logic [ADDR_W-1:0] nb_offset(input logic [2:0] nb);
    logic [ADDR_W-1:0] off;
    unique case (nb)
      NB_RIGHT: off = 16'h0001;
      NB_LEFT:  off = 16'hffff;
      NB_DOWN:  off = 16'h0100;
      NB_UP:    off = 16'hff00;
      default:  off = 16'h0000;
    endcase
    return off;
  endfunction

endpackage

FILE: design/bie_ram.sv
// Generic single-port RAM, registered read; read data holds between reads.
// No dependencies.
module bie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle: write, or registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: design/bie_alu.sv
// Shared accumulator unit: load, add, subtract, bias-minus and divide by three.
// Depends on bie_pkg.
module bie_alu
  import bie_pkg::*;
(
  input  logic              clk,
  input  logic [2:0]        op,
  input  logic [ADDR_W-1:0] opnd,
  output logic [ADDR_W-1:0] acc
);

  logic [2*SUM_W-1:0] prod;
  logic [ADDR_W-1:0]  acc_next;

  // reciprocal multiply for the channel average
  assign prod = acc[SUM_W-1:0] * DIV3_MUL;

  always_comb begin
    unique case (op)
      ALU_LOAD: acc_next = opnd;
      ALU_ADD:  acc_next = acc + opnd;
      ALU_SUB:  acc_next = acc - opnd;
      ALU_BIAS: acc_next = BIAS_C - opnd;
      ALU_DIV3: acc_next = ADDR_W'(prod[2*SUM_W-1:DIV3_SHIFT]);
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule

FILE: design/bie_seq.sv
// Sequencer: steps each item through the shared unit and the three stores.
// Depends on bie_pkg and the assertion macro header.
`include "bump_index_and_envmap_shade_macros.svh"

module bie_seq
  import bie_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] opcode,
  input  logic       bump_present,
  output logic       busy,
  output bie_ctrl_t  ctrl
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_LD_R    = 5'd1;
  localparam logic [4:0] ST_LD_G    = 5'd2;
  localparam logic [4:0] ST_LD_B    = 5'd3;
  localparam logic [4:0] ST_LD_DIV  = 5'd4;
  localparam logic [4:0] ST_LD_WR   = 5'd5;
  localparam logic [4:0] ST_LT_WR   = 5'd6;
  localparam logic [4:0] ST_BD_1    = 5'd7;
  localparam logic [4:0] ST_BD_2    = 5'd8;
  localparam logic [4:0] ST_BD_3    = 5'd9;
  localparam logic [4:0] ST_BD_4    = 5'd10;
  localparam logic [4:0] ST_BD_5    = 5'd11;
  localparam logic [4:0] ST_BD_6    = 5'd12;
  localparam logic [4:0] ST_BD_7    = 5'd13;
  localparam logic [4:0] ST_SH_1    = 5'd14;
  localparam logic [4:0] ST_SH_2    = 5'd15;
  localparam logic [4:0] ST_SH_3    = 5'd16;
  localparam logic [4:0] ST_SH_4    = 5'd17;
  localparam logic [4:0] ST_SH_ZERO = 5'd18;

  logic [4:0] state;
  logic [4:0] state_next;

  assign busy = (state != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-state control; heights arrive in the cycle after their read
  always_comb begin
    ctrl       = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (opcode)
            OP_LOAD:  state_next = ST_LD_R;
            OP_BUILD: state_next = ST_BD_1;
            OP_LIGHT: state_next = ST_LT_WR;
            default:  state_next = bump_present ? ST_SH_1 : ST_SH_ZERO;
          endcase
        end
      end
      // height load: sum of channels, then divide by three
      ST_LD_R: begin
        ctrl.alu_op = ALU_LOAD;
        ctrl.opnd   = OPN_RED;
        state_next  = ST_LD_G;
      end
      ST_LD_G: begin
        ctrl.alu_op = ALU_ADD;
        ctrl.opnd   = OPN_GREEN;
        state_next  = ST_LD_B;
      end
      ST_LD_B: begin
        ctrl.alu_op = ALU_ADD;
        ctrl.opnd   = OPN_BLUE;
        state_next  = ST_LD_DIV;
      end
      ST_LD_DIV: begin
        ctrl.alu_op = ALU_DIV3;
        state_next  = ST_LD_WR;
      end
      ST_LD_WR: begin
        ctrl.h_wr  = 1'b1;
        ctrl.h_nb  = NB_SELF;
        state_next = ST_IDLE;
      end
      // light byte write
      ST_LT_WR: begin
        ctrl.l_wr  = 1'b1;
        state_next = ST_IDLE;
      end
      // build: bx from right/left, by from down/up
      ST_BD_1: begin
        ctrl.alu_op = ALU_BIAS;
        ctrl.opnd   = OPN_X;
        ctrl.h_rd   = 1'b1;
        ctrl.h_nb   = NB_RIGHT;
        state_next  = ST_BD_2;
      end
      ST_BD_2: begin
        ctrl.alu_op = ALU_ADD;
        ctrl.opnd   = OPN_HDATA;
        ctrl.h_rd   = 1'b1;
        ctrl.h_nb   = NB_LEFT;
        state_next  = ST_BD_3;
      end
      ST_BD_3: begin
        ctrl.alu_op = ALU_SUB;
        ctrl.opnd   = OPN_HDATA;
        ctrl.h_rd   = 1'b1;
        ctrl.h_nb   = NB_DOWN;
        state_next  = ST_BD_4;
      end
      ST_BD_4: begin
        ctrl.save_bx = 1'b1;
        ctrl.alu_op  = ALU_BIAS;
        ctrl.opnd    = OPN_Y;
        state_next   = ST_BD_5;
      end
      ST_BD_5: begin
        ctrl.alu_op = ALU_ADD;
        ctrl.opnd   = OPN_HDATA;
        ctrl.h_rd   = 1'b1;
        ctrl.h_nb   = NB_UP;
        state_next  = ST_BD_6;
      end
      ST_BD_6: begin
        ctrl.alu_op = ALU_SUB;
        ctrl.opnd   = OPN_HDATA;
        state_next  = ST_BD_7;
      end
      ST_BD_7: begin
        ctrl.b_wr  = 1'b1;
        ctrl.emit  = 1'b1;
        ctrl.kind  = KIND_BUMP;
        state_next = ST_IDLE;
      end
      // shade: index plus scroll, then light lookup
      ST_SH_1: begin
        ctrl.b_rd   = 1'b1;
        ctrl.alu_op = ALU_LOAD;
        ctrl.opnd   = OPN_OFFSET;
        state_next  = ST_SH_2;
      end
      ST_SH_2: begin
        ctrl.alu_op = ALU_ADD;
        ctrl.opnd   = OPN_BDATA;
        state_next  = ST_SH_3;
      end
      ST_SH_3: begin
        ctrl.l_rd  = 1'b1;
        ctrl.l_acc = 1'b1;
        state_next = ST_SH_4;
      end
      ST_SH_4: begin
        ctrl.emit  = 1'b1;
        ctrl.kind  = KIND_SHADE;
        state_next = ST_IDLE;
      end
      ST_SH_ZERO: begin
        ctrl.emit  = 1'b1;
        ctrl.kind  = KIND_SHADE;
        ctrl.zero  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `BIE_ASSERT_NXT(a_accept_leaves_idle, (state == ST_IDLE) && start, state != ST_IDLE, "accepted item did not start")
  `BIE_ASSERT_NXT(a_emit_ends_item, ctrl.emit, state == ST_IDLE, "result not at end of item")
  `BIE_ASSERT_IMP(a_one_store_access, 1'b1, $onehot0({ctrl.h_rd, ctrl.h_wr, ctrl.b_rd, ctrl.b_wr, ctrl.l_rd, ctrl.l_wr}), "two store accesses in one cycle")
  `BIE_ASSERT_NXT(a_shade_gated, (state == ST_IDLE) && start && (opcode == OP_SHADE) && !bump_present, state == ST_SH_ZERO, "shade without bump map read stores")

endmodule

FILE: design/bump_index_and_envmap_shade.sv
// Top level of the bump index / environment map shader.
// Depends on bie_pkg, bie_ram, bie_alu and bie_seq.
//
// Usage:
// - Items: drive opcode, position and the data fields with start high; the
//   item is taken at a clock edge where start is high and busy is low.
// - Opcodes: load height, light byte write, build bump index, shade pixel (a
//   zero result when no bump map is present).
// - Build and shade each give one result beat: result_valid is high for one
//   cycle, the cycle after the last busy cycle; busy is already low then, so
//   the next item may be started in that cycle.
// - The length of an item is set by the single-port height store (four
//   neighbour reads) and the one shared accumulator.
// - Configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is
//   the light scroll byte, index 1 the bump-map-present flag, others ignored.
//   Write only while the block is idle.
// - Reset clears the sequencer, the result strobe and both registers; the
//   stores keep no reset state and must be written before they are read.
// - The receiver cannot stall: every result beat is taken as it is shown.
module bump_index_and_envmap_shade
  import bie_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  logic [ADDR_W-1:0]    position,
  input  logic [BYTE_W-1:0]    red,
  input  logic [BYTE_W-1:0]    green,
  input  logic [BYTE_W-1:0]    blue,
  input  logic [BYTE_W-1:0]    light_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output logic                 result_valid,
  output logic [ADDR_W-1:0]    result_value,
  output logic [ADDR_W-1:0]    result_position,
  output logic                 result_kind
);

  bie_ctrl_t         ctrl;
  logic              accept;
  logic [ADDR_W-1:0] pos_q;
  logic [BYTE_W-1:0] red_q;
  logic [BYTE_W-1:0] green_q;
  logic [BYTE_W-1:0] blue_q;
  logic [BYTE_W-1:0] lv_q;
  logic [BYTE_W-1:0] bx;
  logic [BYTE_W-1:0] light_offset;
  logic              bump_present;
  logic [ADDR_W-1:0] acc;
  logic [ADDR_W-1:0] opnd;
  logic [ADDR_W-1:0] h_addr;
  logic [ADDR_W-1:0] l_addr;
  logic [BYTE_W-1:0] h_rdata;
  logic [ADDR_W-1:0] b_rdata;
  logic [BYTE_W-1:0] l_rdata;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      light_offset <= '0;
      bump_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LIGHT_OFFSET) begin
        light_offset <= cfg_data;
      end else if (cfg_index == REG_BUMP_PRESENT) begin
        bump_present <= cfg_data[0];
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q   <= position;
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      lv_q    <= light_value;
    end
  end

  bie_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .opcode       (opcode),
    .bump_present (bump_present),
    .busy         (busy),
    .ctrl         (ctrl)
  );

  // operand select for the shared unit
  always_comb begin
    unique case (ctrl.opnd)
      OPN_RED:    opnd = ADDR_W'(red_q);
      OPN_GREEN:  opnd = ADDR_W'(green_q);
      OPN_BLUE:   opnd = ADDR_W'(blue_q);
      OPN_X:      opnd = ADDR_W'(pos_q[BYTE_W-1:0]);
      OPN_Y:      opnd = ADDR_W'(pos_q[ADDR_W-1:BYTE_W]);
      OPN_HDATA:  opnd = ADDR_W'(h_rdata);
      OPN_BDATA:  opnd = b_rdata;
      default:    opnd = ADDR_W'(light_offset);
    endcase
  end

  bie_alu u_alu (
    .clk  (clk),
    .op   (ctrl.alu_op),
    .opnd (opnd),
    .acc  (acc)
  );

  // bx kept while by is worked out
  always_ff @(posedge clk) begin
    if (ctrl.save_bx) begin
      bx <= acc[BYTE_W-1:0];
    end
  end

  // store addressing
  assign h_addr = pos_q + nb_offset(ctrl.h_nb);
  assign l_addr = ctrl.l_acc ? acc : pos_q;

  bie_ram #(.WIDTH(BYTE_W), .DEPTH(1 << ADDR_W)) u_height (
    .clk   (clk),
    .en    (ctrl.h_rd || ctrl.h_wr),
    .we    (ctrl.h_wr),
    .addr  (h_addr),
    .wdata (acc[BYTE_W-1:0]),
    .rdata (h_rdata)
  );

  bie_ram #(.WIDTH(ADDR_W), .DEPTH(1 << ADDR_W)) u_bump (
    .clk   (clk),
    .en    (ctrl.b_rd || ctrl.b_wr),
    .we    (ctrl.b_wr),
    .addr  (pos_q),
    .wdata ({acc[BYTE_W-1:0], bx}),
    .rdata (b_rdata)
  );

  bie_ram #(.WIDTH(BYTE_W), .DEPTH(1 << ADDR_W)) u_light (
    .clk   (clk),
    .en    (ctrl.l_rd || ctrl.l_wr),
    .we    (ctrl.l_wr),
    .addr  (l_addr),
    .wdata (lv_q),
    .rdata (l_rdata)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      result_position <= pos_q;
      result_kind     <= ctrl.kind;
      if (ctrl.kind == KIND_BUMP) begin
        result_value <= {acc[BYTE_W-1:0], bx};
      end else if (ctrl.zero) begin
        result_value <= '0;
      end else begin
        result_value <= ADDR_W'(l_rdata);
      end
    end
  end

endmodule
